// ----- rtl/sil_pkg.sv -----
// Shared types, codes and constants of the sorted insertion list.
package sil_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int ACT_W = 2;
  localparam int KEY_W = 32;
  localparam int PAY_W = 16;
  localparam int POS_W = 4;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_SCAN,
    S_PUSH_LAST,
    S_REM_FIRST,
    S_REM_SHIFT,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_POS,
    RD_DOWN,
    RD_UP
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ENTRY_UP,
    WR_NEW_UP,
    WR_NEW_ZERO,
    WR_ENTRY_DOWN
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FULL,
    RES_BAD,
    RES_OK,
    RES_DATA
  } res_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic key_greater;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/sil_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
module sil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/sil_ctrl.sv -----
// Controller state machine that sequences push, remove and read operations.
module sil_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sil_pkg::ACT_W-1:0]     in_action,
  input  sil_pkg::sts_t                 sts,
  output logic                          in_ready,
  output sil_pkg::cmd_t                 cmd
);

  sil_pkg::state_t state_r;
  sil_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sil_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.rd_sel   = sil_pkg::RD_TOP;
    cmd.wr_sel   = sil_pkg::WR_NONE;
    cmd.cnt_op   = sil_pkg::CNT_HOLD;
    cmd.res_sel  = sil_pkg::RES_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      sil_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sil_pkg::act_t'(in_action))
            sil_pkg::ACT_PUSH: begin
              if (sts.full) begin
                cmd.res_sel = sil_pkg::RES_FULL;
                state_nxt   = sil_pkg::S_FINISH;
              end else if (sts.empty) begin
                state_nxt = sil_pkg::S_PUSH_LAST;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sil_pkg::RD_TOP;
                state_nxt  = sil_pkg::S_PUSH_SCAN;
              end
            end
            sil_pkg::ACT_REMOVE, sil_pkg::ACT_READ: begin
              if (sts.pos_bad) begin
                cmd.res_sel = sil_pkg::RES_BAD;
                state_nxt   = sil_pkg::S_FINISH;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sil_pkg::RD_POS;
                state_nxt  = (sil_pkg::act_t'(in_action) == sil_pkg::ACT_REMOVE) ?
                             sil_pkg::S_REM_FIRST : sil_pkg::S_READ_WAIT;
              end
            end
            sil_pkg::ACT_NOP: begin
              cmd.res_sel = sil_pkg::RES_OK;
              state_nxt   = sil_pkg::S_FINISH;
            end
            default: begin
              state_nxt = sil_pkg::S_IDLE;
            end
          endcase
        end
      end
      sil_pkg::S_PUSH_SCAN: begin
        if (sts.key_greater) begin
          cmd.wr_sel = sil_pkg::WR_ENTRY_UP;
          if (sts.idx_zero) begin
            state_nxt = sil_pkg::S_PUSH_LAST;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sil_pkg::RD_DOWN;
          end
        end else begin
          cmd.wr_sel  = sil_pkg::WR_NEW_UP;
          cmd.cnt_op  = sil_pkg::CNT_INC;
          cmd.res_sel = sil_pkg::RES_OK;
          state_nxt   = sil_pkg::S_FINISH;
        end
      end
      sil_pkg::S_PUSH_LAST: begin
        cmd.wr_sel  = sil_pkg::WR_NEW_ZERO;
        cmd.cnt_op  = sil_pkg::CNT_INC;
        cmd.res_sel = sil_pkg::RES_OK;
        state_nxt   = sil_pkg::S_FINISH;
      end
      sil_pkg::S_REM_FIRST: begin
        cmd.res_sel = sil_pkg::RES_DATA;
        if (sts.idx_last) begin
          cmd.cnt_op = sil_pkg::CNT_DEC;
          state_nxt  = sil_pkg::S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sil_pkg::RD_UP;
          state_nxt  = sil_pkg::S_REM_SHIFT;
        end
      end
      sil_pkg::S_REM_SHIFT: begin
        cmd.wr_sel = sil_pkg::WR_ENTRY_DOWN;
        if (sts.idx_last) begin
          cmd.cnt_op = sil_pkg::CNT_DEC;
          state_nxt  = sil_pkg::S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sil_pkg::RD_UP;
        end
      end
      sil_pkg::S_READ_WAIT: begin
        cmd.res_sel = sil_pkg::RES_DATA;
        state_nxt   = sil_pkg::S_FINISH;
      end
      sil_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sil_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sil_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sil_dp.sv -----
// Datapath with the entry RAM, count, scan index and result registers.
module sil_dp #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sil_pkg::cmd_t              cmd,
  output sil_pkg::sts_t              sts,
  input  logic [sil_pkg::KEY_W-1:0]  in_key,
  input  logic [sil_pkg::PAY_W-1:0]  in_payload,
  input  logic [sil_pkg::POS_W-1:0]  in_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sil_pkg::STAT_W-1:0] out_status,
  output logic [sil_pkg::KEY_W-1:0]  out_key,
  output logic [sil_pkg::PAY_W-1:0]  out_payload,
  output logic [sil_pkg::OCNT_W-1:0] out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > sil_pkg::POS_W) ? CW : sil_pkg::POS_W;
  localparam int EW = sil_pkg::KEY_W + sil_pkg::PAY_W;

  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [AW-1:0]             idx_r;
  logic [sil_pkg::KEY_W-1:0] key_r;
  logic [sil_pkg::PAY_W-1:0] payload_r;

  sil_pkg::status_t          res_status_r;
  logic [sil_pkg::KEY_W-1:0] res_key_r;
  logic [sil_pkg::PAY_W-1:0] res_payload_r;

  logic                       out_valid_r;
  sil_pkg::status_t           out_status_r;
  logic [sil_pkg::KEY_W-1:0]  out_key_r;
  logic [sil_pkg::PAY_W-1:0]  out_payload_r;
  logic [sil_pkg::OCNT_W-1:0] out_count_r;

  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           cnt_ext;
  logic [CW-1:0]             cnt_m1;
  logic [CW-1:0]             idx_p1;
  logic [CW+sil_pkg::OCNT_W-1:0] cnt_wide;
  logic [AW-1:0]             idx_up;
  logic [AW-1:0]             idx_dn;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [EW-1:0]             wr_data;
  logic [AW-1:0]             rd_addr;
  logic [EW-1:0]             rd_data;
  logic [sil_pkg::KEY_W-1:0] rd_key;
  logic [sil_pkg::PAY_W-1:0] rd_payload;

  assign pos_ext    = CMPW'(in_position);
  assign cnt_ext    = CMPW'(count_r);
  assign cnt_m1     = count_r - CW'(1);
  assign idx_p1     = CW'(idx_r) + CW'(1);
  assign cnt_wide   = {{sil_pkg::OCNT_W{1'b0}}, count_r};
  assign idx_up     = idx_r + AW'(1);
  assign idx_dn     = idx_r - AW'(1);
  assign rd_key     = rd_data[EW-1:sil_pkg::PAY_W];
  assign rd_payload = rd_data[sil_pkg::PAY_W-1:0];

  assign sts.full        = (count_r == CW'(CAPACITY));
  assign sts.empty       = (count_r == '0);
  assign sts.pos_bad     = (pos_ext >= cnt_ext);
  assign sts.key_greater = (rd_key > key_r);
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.idx_last    = (idx_p1 == count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.rd_sel)
      sil_pkg::RD_TOP:  rd_addr = cnt_m1[AW-1:0];
      sil_pkg::RD_POS:  rd_addr = pos_ext[AW-1:0];
      sil_pkg::RD_DOWN: rd_addr = idx_dn;
      sil_pkg::RD_UP:   rd_addr = idx_up;
      default:          rd_addr = idx_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_up;
    wr_data = rd_data;
    unique case (cmd.wr_sel)
      sil_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      sil_pkg::WR_ENTRY_UP: begin
        wr_addr = idx_up;
        wr_data = rd_data;
      end
      sil_pkg::WR_NEW_UP: begin
        wr_addr = idx_up;
        wr_data = {key_r, payload_r};
      end
      sil_pkg::WR_NEW_ZERO: begin
        wr_addr = '0;
        wr_data = {key_r, payload_r};
      end
      sil_pkg::WR_ENTRY_DOWN: begin
        wr_addr = idx_dn;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  sil_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    unique case (cmd.cnt_op)
      sil_pkg::CNT_HOLD: count_nxt = count_r;
      sil_pkg::CNT_INC:  count_nxt = count_r + CW'(1);
      sil_pkg::CNT_DEC:  count_nxt = cnt_m1;
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r     <= in_key;
      payload_r <= in_payload;
    end
    if (cmd.rd_en) begin
      idx_r <= rd_addr;
    end
    unique case (cmd.res_sel)
      sil_pkg::RES_NONE: begin
      end
      sil_pkg::RES_FULL: begin
        res_status_r  <= sil_pkg::ST_FULL;
        res_key_r     <= '0;
        res_payload_r <= '0;
      end
      sil_pkg::RES_BAD: begin
        res_status_r  <= sil_pkg::ST_BAD_INDEX;
        res_key_r     <= '0;
        res_payload_r <= '0;
      end
      sil_pkg::RES_OK: begin
        res_status_r  <= sil_pkg::ST_OK;
        res_key_r     <= '0;
        res_payload_r <= '0;
      end
      sil_pkg::RES_DATA: begin
        res_status_r  <= sil_pkg::ST_OK;
        res_key_r     <= rd_key;
        res_payload_r <= rd_payload;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_key_r     <= res_key_r;
      out_payload_r <= res_payload_r;
      out_count_r   <= cnt_wide[sil_pkg::OCNT_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_payload = out_payload_r;
  assign out_count   = out_count_r;

endmodule

// ----- rtl/sorted_insert_list_unit.sv -----
// Top level of the sorted insertion list: controller, datapath and checks.
// The list holds up to CAPACITY entries of a 32-bit key and a 16-bit payload in
// ascending key order, with equal keys kept in arrival order, in a RAM with one
// write and one registered read port. One item is worked on at a time, and
// every item gives exactly one result transfer that carries the status and the
// entry count after the item. A push moves each stored entry whose key is greater
// than the new key up by one place and then writes the new entry, a remove
// moves each entry behind the removed one down by one place, and a read
// returns the entry at the position; a refused item and the unused action code go
// straight to the result. Entries move one per cycle through the RAM port.
// The next item is accepted once the previous result is in the output register.
module sorted_insert_list_unit #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sil_pkg::ACT_W-1:0]  in_action,
  input  logic [sil_pkg::KEY_W-1:0]  in_key,
  input  logic [sil_pkg::PAY_W-1:0]  in_payload,
  input  logic [sil_pkg::POS_W-1:0]  in_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sil_pkg::STAT_W-1:0] out_status,
  output logic [sil_pkg::KEY_W-1:0]  out_key,
  output logic [sil_pkg::PAY_W-1:0]  out_payload,
  output logic [sil_pkg::OCNT_W-1:0] out_count
);

  sil_pkg::cmd_t cmd;
  sil_pkg::sts_t sts;

  sil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sil_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_key     (in_key),
    .in_payload (in_payload),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_payload(out_payload),
    .out_count  (out_count)
  );

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sil_pkg::ST_FULL) |->
      (out_count == sil_pkg::OCNT_W'(CAPACITY)))
    else $error("Full status with a count other than the capacity.");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == sil_pkg::ST_FULL) ||
                  (out_status == sil_pkg::ST_BAD_INDEX)) |->
      (out_key == '0) && (out_payload == '0))
    else $error("Refused item returned a nonzero entry.");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == sil_pkg::CNT_INC |-> !sts.full)
    else $error("Entry count incremented on a full list.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == sil_pkg::CNT_DEC |-> !sts.empty)
    else $error("Entry count decremented on an empty list.");

endmodule

// ----- sim/sorted_insert_list_unit_tb.sv -----
// Self-checking testbench of the sorted insertion list: directed table, then random traffic.
`timescale 1ns / 1ps

module sorted_insert_list_unit_tb;

  localparam int ACT_W = sil_pkg::ACT_W;
  localparam int KEY_W = sil_pkg::KEY_W;
  localparam int PAY_W = sil_pkg::PAY_W;
  localparam int POS_W = sil_pkg::POS_W;
  localparam int STAT_W = sil_pkg::STAT_W;
  localparam int OCNT_W = sil_pkg::OCNT_W;
  localparam int LIST_DEPTH = sil_pkg::CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    sil_pkg::status_t    status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [OCNT_W-1:0]   count;
  } list_result_t;

  typedef struct {
    sil_pkg::act_t       act;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [POS_W-1:0]    pos;
    int                  reps;
    bit                  typed;
    list_result_t        want;
  } stim_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND,
    MIX_NOISE
  } mix_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action;
  logic [KEY_W-1:0]    in_key;
  logic [PAY_W-1:0]    in_payload;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_ready;
  logic [STAT_W-1:0]   out_status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [OCNT_W-1:0]   out_count;

  logic [KEY_W-1:0]    mirror_keys [LIST_DEPTH];
  logic [PAY_W-1:0]    mirror_pays [LIST_DEPTH];
  int                  mirror_count;

  list_result_t        pending_results [$];
  stim_row_t           dir_rows [$];
  int                  mismatch_count = 0;
  int                  idle_cycles = 0;

  sorted_insert_list_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_key      (in_key),
    .in_payload  (in_payload),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_count   (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(input sil_pkg::act_t act,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [PAY_W-1:0] p,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int n;
    int slot;
    int i;
    r.status = sil_pkg::ST_OK;
    r.key = '0;
    r.payload = '0;
    n = mirror_count;
    case (act)
      sil_pkg::ACT_PUSH: begin
        if (n >= LIST_DEPTH) begin
          r.status = sil_pkg::ST_FULL;
        end else begin
          slot = n;
          for (i = 0; i < n; i++) begin
            if (slot == n && mirror_keys[i] > k) begin
              slot = i;
            end
          end
          for (i = n; i > slot; i--) begin
            mirror_keys[i] = mirror_keys[i-1];
            mirror_pays[i] = mirror_pays[i-1];
          end
          mirror_keys[slot] = k;
          mirror_pays[slot] = p;
          mirror_count = n + 1;
        end
      end
      sil_pkg::ACT_REMOVE, sil_pkg::ACT_READ: begin
        if (int'(pos) >= n) begin
          r.status = sil_pkg::ST_BAD_INDEX;
        end else begin
          r.key = mirror_keys[pos];
          r.payload = mirror_pays[pos];
          if (act == sil_pkg::ACT_REMOVE) begin
            for (i = int'(pos); i + 1 < n; i++) begin
              mirror_keys[i] = mirror_keys[i+1];
              mirror_pays[i] = mirror_pays[i+1];
            end
            mirror_count = n - 1;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = mirror_count[OCNT_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 7));
      5: return 32'hFFFF_FFF8 + KEY_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic drive_item(input sil_pkg::act_t act, input logic [KEY_W-1:0] k,
                            input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos,
                            input int gap, input bit typed, input list_result_t want);
    list_result_t got;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_payload <= p;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = apply_list_op(act, k, p, pos);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic note_mismatch(input string what, input list_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected st=%0d key=%h pay=%h cnt=%0d, got st=%0d key=%h pay=%h cnt=%0d",
               what, want.status, want.key, want.payload, want.count,
               out_status, out_key, out_payload, out_count);
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected result transfer", want);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_key !== want.key ||
            out_payload !== want.payload || out_count !== want.count) begin
          note_mismatch("result mismatch", want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_insert_list_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int made;
    int len;
    int roll;
    bit steady;
    mix_t mix;
    sil_pkg::act_t act;
    logic [POS_W-1:0] pos;
    mirror_count = 0;
    for (r = 0; r < LIST_DEPTH; r++) begin
      mirror_keys[r] = '0;
      mirror_pays[r] = '0;
    end
    in_valid <= 1'b0;
    in_action <= sil_pkg::ACT_NOP;
    in_key <= '0;
    in_payload <= '0;
    in_position <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         '{sil_pkg::ST_BAD_INDEX, 32'h0, 16'h0, 5'd0}});
    dir_rows.push_back('{sil_pkg::ACT_REMOVE, 32'h0, 16'h0, 4'd15, 1, 1'b1,
                         '{sil_pkg::ST_BAD_INDEX, 32'h0, 16'h0, 5'd0}});
    dir_rows.push_back('{sil_pkg::ACT_NOP, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 1, 1'b1,
                         '{sil_pkg::ST_OK, 32'h0, 16'h0, 5'd0}});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1, 1'b1,
                         '{sil_pkg::ST_OK, 32'h0, 16'h0, 5'd1}});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         '{sil_pkg::ST_OK, 32'h0, 16'h0, 5'd2}});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h0, 16'h1234, 4'd0, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h5, 16'hAAAA, 4'd0, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd0, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd1, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd3, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd4, 1, 1'b1,
                         '{sil_pkg::ST_BAD_INDEX, 32'h0, 16'h0, 5'd4}});
    dir_rows.push_back('{sil_pkg::ACT_REMOVE, 32'h0, 16'h0, 4'd1, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h8000_0000, 16'h5555, 4'd0, 13, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h1, 16'h0F0F, 4'd0, 1, 1'b1,
                         '{sil_pkg::ST_FULL, 32'h0, 16'h0, 5'd16}});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd15, 1, 1'b1,
                         '{sil_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 5'd16}});
    dir_rows.push_back('{sil_pkg::ACT_REMOVE, 32'h0, 16'h0, 4'd15, 1, 1'b1,
                         '{sil_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 5'd15}});
    dir_rows.push_back('{sil_pkg::ACT_READ, 32'h0, 16'h0, 4'd15, 1, 1'b1,
                         '{sil_pkg::ST_BAD_INDEX, 32'h0, 16'h0, 5'd15}});
    dir_rows.push_back('{sil_pkg::ACT_REMOVE, 32'h0, 16'h0, 4'd0, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_PUSH, 32'h7FFF_FFFF, 16'h0, 4'd0, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_REMOVE, 32'h0, 16'h0, 4'd7, 1, 1'b0, '0});
    dir_rows.push_back('{sil_pkg::ACT_NOP, 32'h0, 16'h0, 4'd0, 1, 1'b0, '0});

    foreach (dir_rows[i]) begin
      for (r = 0; r < dir_rows[i].reps; r++) begin
        drive_item(dir_rows[i].act, dir_rows[i].key + KEY_W'(r),
                   dir_rows[i].payload ^ PAY_W'(r), dir_rows[i].pos, pick_gap(),
                   dir_rows[i].typed, dir_rows[i].want);
      end
    end

    made = 0;
    while (made < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 3));
      len = $urandom_range(10, 40);
      steady = ($urandom_range(0, 4) == 0);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  act = roll < 80 ? sil_pkg::ACT_PUSH :
                           (roll < 90 ? sil_pkg::ACT_READ : sil_pkg::ACT_REMOVE);
          MIX_DRAIN: act = roll < 65 ? sil_pkg::ACT_REMOVE :
                           (roll < 85 ? sil_pkg::ACT_READ : sil_pkg::ACT_PUSH);
          MIX_BLEND: act = roll < 40 ? sil_pkg::ACT_PUSH :
                           (roll < 70 ? sil_pkg::ACT_REMOVE :
                           (roll < 95 ? sil_pkg::ACT_READ : sil_pkg::ACT_NOP));
          default:   act = sil_pkg::act_t'($urandom_range(0, 3));
        endcase
        if (mix != MIX_NOISE && mirror_count > 0 && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, mirror_count - 1));
        end else begin
          pos = POS_W'($urandom_range(0, 15));
        end
        drive_item(act, pick_key(), PAY_W'($urandom), pos, steady ? 0 : pick_gap(),
                   1'b0, '0);
        if (act != sil_pkg::ACT_NOP) begin
          made++;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_insert_list_unit verification clean");
    end else begin
      $display("sorted_insert_list_unit verification failed");
    end
    $finish;
  end

endmodule
